FILE: design/spwm_pkg.sv
`timescale 1ns / 1ps

package spwm_pkg;

    // Default sizes of the table and the phase word.
    localparam int TABLE_DEPTH_DEF     = 1024;
    localparam int PHASE_FRAC_BITS_DEF = 16;
    localparam int SAMPLE_WIDTH_DEF    = 16;

    // Fixed field and register widths.
    localparam int OP_W          = 1;
    localparam int ENTRY_INDEX_W = 10;
    localparam int ENTRY_VALUE_W = 16;
    localparam int DUTY_W        = 16;
    localparam int SIZE_W        = 11;
    localparam int STEP_W        = 26;
    localparam int AMP_W         = 16;
    localparam int CFG_INDEX_W   = 2;
    localparam int CFG_DATA_W    = 26;

    // Amplitude and table size limits and reset values.
    localparam int AMP_FRAC_BITS    = 15;
    localparam logic [AMP_W-1:0] AMP_ONE = 16'd32768;
    localparam int TABLE_SIZE_MIN   = 64;
    localparam int TABLE_SIZE_RESET = 1024;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_TABLE_SIZE = 2'd0,
        REG_PHASE_STEP = 2'd1,
        REG_AMPLITUDE  = 2'd2,
        REG_ENABLE     = 2'd3
    } cfg_reg_t;

    // Item operation codes.
    typedef enum logic [OP_W-1:0] {
        OP_TICK  = 1'b0,
        OP_WRITE = 1'b1
    } op_t;

endpackage

FILE: design/spwm_if.sv
`timescale 1ns / 1ps

// Input channel: carrier ticks and sine table writes.
interface spwm_in_if;
    logic                               valid;
    logic                               ready;
    logic                               operation;
    logic [spwm_pkg::ENTRY_INDEX_W-1:0] entry_index;
    logic [spwm_pkg::ENTRY_VALUE_W-1:0] entry_value;

    modport source (output valid, operation, entry_index, entry_value, input ready);
    modport sink (input valid, operation, entry_index, entry_value, output ready);
endinterface

// Output channel: one compare value per enabled tick.
interface spwm_out_if;
    logic                        valid;
    logic                        ready;
    logic [spwm_pkg::DUTY_W-1:0] duty;

    modport source (output valid, duty, input ready);
    modport sink (input valid, duty, output ready);
endinterface

FILE: design/spwm_ram.sv
`timescale 1ns / 1ps

module spwm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // One write port, one registered read port; read data holds when not enabled.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: design/spwm_phase_accumulator_duty.sv
`timescale 1ns / 1ps

// Channel   Direction  Beat contents
// item      in         operation, entry_index, entry_value
// result    out        duty
//
// One item can be accepted every cycle unless a tick waits in the RAM stage
// behind a stalled output. A table write completes at its beat. An enabled
// tick updates the phase and reads the sine RAM at its beat; its duty then
// moves from the RAM read register to the output register when that is free.
// Reset clears control and configuration; the sine RAM is not cleared.
// A stalled output holds its beat while one more tick waits in the RAM stage.
module spwm_phase_accumulator_duty #(
    parameter int TABLE_DEPTH     = spwm_pkg::TABLE_DEPTH_DEF,
    parameter int PHASE_FRAC_BITS = spwm_pkg::PHASE_FRAC_BITS_DEF,
    parameter int SAMPLE_WIDTH    = spwm_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [spwm_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [spwm_pkg::CFG_DATA_W-1:0]  cfg_data,
    spwm_in_if.sink                          item,
    spwm_out_if.source                       result
);

    import spwm_pkg::*;

    localparam int AW     = $clog2(TABLE_DEPTH);
    localparam int PH_W   = AW + PHASE_FRAC_BITS;
    localparam int LIM_W  = PH_W + 1;
    localparam int CW     = (STEP_W > LIM_W) ? STEP_W : LIM_W;
    localparam int PROD_W = SAMPLE_WIDTH + AMP_W;
    localparam int SIZE_RST_EFF =
        (TABLE_SIZE_RESET > TABLE_DEPTH) ? TABLE_DEPTH : TABLE_SIZE_RESET;
    localparam logic [LIM_W-1:0] LIMIT_RST = LIM_W'(SIZE_RST_EFF) << PHASE_FRAC_BITS;

    // Configuration state, kept in the form the tick path uses.
    logic [LIM_W-1:0]  limit_reg, limit_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [PH_W-1:0]   step_eff_reg, step_eff_next;
    logic [AMP_W-1:0]  amp_reg, amp_next;
    logic              enable_reg, enable_next;

    // Phase and pipeline state.
    logic [PH_W-1:0]   phase_reg, phase_next;
    logic              s1_valid_reg, s1_valid_next;
    logic              s2_valid_reg, s2_valid_next;
    logic [DUTY_W-1:0] duty_reg, duty_next;

    logic [CW-1:0]           cfg_size;
    logic [CW-1:0]           cfg_limit;
    logic [CW-1:0]           clamp_step;
    logic [CW-1:0]           clamp_lim;
    logic [CW-1:0]           clamp_res;
    logic [LIM_W-1:0]        phase_sum;
    logic [LIM_W-1:0]        phase_wrap;
    logic [PH_W-1:0]         phase_upd;
    logic                    item_beat;
    logic                    tick_go;
    logic                    s2_load;
    logic                    ram_wr_en;
    logic [SAMPLE_WIDTH-1:0] ram_rdata;
    logic [PROD_W-1:0]       product;

    // Configuration writes: clamp table size, amplitude and phase step once.
    always_comb
    begin
        limit_next    = limit_reg;
        step_next     = step_reg;
        step_eff_next = step_eff_reg;
        amp_next      = amp_reg;
        enable_next   = enable_reg;

        cfg_size = CW'(cfg_data[SIZE_W-1:0]);
        if (cfg_size < CW'(TABLE_SIZE_MIN))
        begin
            cfg_size = CW'(TABLE_SIZE_MIN);
        end
        if (cfg_size > CW'(TABLE_DEPTH))
        begin
            cfg_size = CW'(TABLE_DEPTH);
        end
        cfg_limit = cfg_size << PHASE_FRAC_BITS;

        // A single compare serves both a size write and a step write.
        if (cfg_index == REG_TABLE_SIZE)
        begin
            clamp_step = CW'(step_reg);
            clamp_lim  = cfg_limit;
        end
        else
        begin
            clamp_step = CW'(cfg_data[STEP_W-1:0]);
            clamp_lim  = CW'(limit_reg);
        end
        clamp_res = (clamp_step >= clamp_lim) ? (clamp_lim - CW'(1)) : clamp_step;

        if (cfg_write)
        begin
            case (cfg_index)
                REG_TABLE_SIZE:
                begin
                    limit_next    = LIM_W'(cfg_limit);
                    step_eff_next = PH_W'(clamp_res);
                end
                REG_PHASE_STEP:
                begin
                    step_next     = cfg_data[STEP_W-1:0];
                    step_eff_next = PH_W'(clamp_res);
                end
                REG_AMPLITUDE:
                begin
                    amp_next = (cfg_data[AMP_W-1:0] > AMP_ONE) ? AMP_ONE : cfg_data[AMP_W-1:0];
                end
                REG_ENABLE:
                begin
                    enable_next = cfg_data[0];
                end
                default:
                begin
                    enable_next = enable_reg;
                end
            endcase
        end
    end

    // Phase accumulate with a single wrap; a phase left past a shrunk table restarts.
    always_comb
    begin
        phase_sum = LIM_W'(phase_reg) + LIM_W'(step_eff_reg);
        if (phase_sum >= limit_reg)
        begin
            phase_wrap = phase_sum - limit_reg;
        end
        else
        begin
            phase_wrap = phase_sum;
        end
        if (phase_wrap >= limit_reg)
        begin
            phase_upd = '0;
        end
        else
        begin
            phase_upd = PH_W'(phase_wrap);
        end
    end

    // Handshake and pipeline advance.
    assign item_beat = item.valid && item.ready;
    assign tick_go   = item_beat && (item.operation == OP_TICK) && enable_reg;
    assign ram_wr_en = item_beat && (item.operation == OP_WRITE)
                       && (32'(item.entry_index) < TABLE_DEPTH);
    assign s2_load   = s1_valid_reg && (!s2_valid_reg || result.ready);
    assign item.ready = !s1_valid_reg || s2_load;

    assign product = PROD_W'(ram_rdata) * PROD_W'(amp_reg);

    always_comb
    begin
        phase_next    = tick_go ? phase_upd : phase_reg;
        s1_valid_next = tick_go ? 1'b1 : (s2_load ? 1'b0 : s1_valid_reg);
        s2_valid_next = s2_load ? 1'b1 : (result.ready ? 1'b0 : s2_valid_reg);
        duty_next     = s2_load ? DUTY_W'(product >> AMP_FRAC_BITS) : duty_reg;
    end

    // Sine table memory.
    spwm_ram #(
        .WIDTH (SAMPLE_WIDTH),
        .DEPTH (TABLE_DEPTH)
    ) u_sine_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (AW'(item.entry_index)),
        .wr_data (item.entry_value[SAMPLE_WIDTH-1:0]),
        .rd_en   (tick_go),
        .rd_addr (phase_upd[PH_W-1:PHASE_FRAC_BITS]),
        .rd_data (ram_rdata)
    );

    // Control and configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg    <= LIMIT_RST;
            step_reg     <= '0;
            step_eff_reg <= '0;
            amp_reg      <= AMP_ONE;
            enable_reg   <= 1'b0;
            phase_reg    <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            limit_reg    <= limit_next;
            step_reg     <= step_next;
            step_eff_reg <= step_eff_next;
            amp_reg      <= amp_next;
            enable_reg   <= enable_next;
            phase_reg    <= phase_next;
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    // Output payload register.
    always_ff @(posedge clk)
    begin
        duty_reg <= duty_next;
    end

    assign result.valid = s2_valid_reg;
    assign result.duty  = duty_reg;

`ifndef SYNTHESIS
    // The clamped step always stays below the wrap limit.
    assert property (@(posedge clk) disable iff (!rst_n)
        LIM_W'(step_eff_reg) < limit_reg)
        else $error("clamped phase step not below wrap limit");

    // The stored amplitude never exceeds one.
    assert property (@(posedge clk) disable iff (!rst_n)
        amp_reg <= AMP_ONE)
        else $error("amplitude above one");

    // A table write leaves the phase untouched.
    assert property (@(posedge clk) disable iff (!rst_n)
        (item_beat && (item.operation == OP_WRITE)) |=> $stable(phase_reg))
        else $error("table write moved the phase");

    // RAM read data of a waiting tick must hold until it moves on.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s2_load) |=> $stable(ram_rdata))
        else $error("RAM stage data lost while stalled");
`endif

endmodule
